// ===== rtl/stra_pkg.sv =====
package stra_pkg;

  // field widths
  localparam int REGION_W = 24;
  localparam int REQ_W    = 16;
  localparam int TILE_W   = 13;
  localparam int DIM_W    = 24;
  localparam int ST_W     = 25;
  localparam int PAD_W    = 17;
  localparam int CMP_W    = 27;

  // stream payloads
  localparam int IN_W       = 2 * REGION_W + 2 * REQ_W;
  localparam int OUT_W      = 2 * DIM_W + 2 * REGION_W;
  localparam int OUT_USER_W = 2;

  // remainder unit
  localparam int DIV_CNT_W = 4;

  // register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_TILE_COLS    = 2'd0;
  localparam logic [1:0] REG_TILE_ROWS    = 2'd1;
  localparam logic [1:0] REG_STORE_WIDTH  = 2'd2;
  localparam logic [1:0] REG_STORE_HEIGHT = 2'd3;

  localparam logic [TILE_W-1:0] TILE_COLS_RESET    = 13'd128;
  localparam logic [TILE_W-1:0] TILE_ROWS_RESET    = 13'd64;
  localparam logic [DIM_W-1:0]  STORE_WIDTH_RESET  = 24'hFFFFFF;
  localparam logic [DIM_W-1:0]  STORE_HEIGHT_RESET = 24'hFFFFFF;

  localparam logic [ST_W-1:0] SHELF_TOP_RESET = 25'd20000;

  typedef struct packed {
    logic [TILE_W-1:0] tile_cols;
    logic [TILE_W-1:0] tile_rows;
    logic [DIM_W-1:0]  store_width;
    logic [DIM_W-1:0]  store_height;
  } cfg_t;

endpackage

// ===== rtl/stra_rem_div.sv =====
module stra_rem_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [stra_pkg::REQ_W-1:0]    dividend,
  input  logic [stra_pkg::TILE_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [stra_pkg::TILE_W-1:0]   remainder
);
  import stra_pkg::*;

  // restoring division, one dividend bit per cycle; only the remainder is kept
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [REQ_W-1:0]      shift_r, shift_nxt;
  logic [TILE_W-1:0]     rem_r, rem_nxt;
  logic [TILE_W-1:0]     dsr_r, dsr_nxt;
  logic [TILE_W:0]       trial;
  logic [TILE_W:0]       diff;

  assign trial = {rem_r, shift_r[REQ_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    dsr_nxt   = dsr_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = DIV_CNT_W'(REQ_W - 1);
      shift_nxt = dividend;
      rem_nxt   = '0;
      dsr_nxt   = divisor;
    end else if (busy_r) begin
      shift_nxt = {shift_r[REQ_W-2:0], 1'b0};
      rem_nxt   = (trial >= {1'b0, dsr_r}) ? diff[TILE_W-1:0] : trial[TILE_W-1:0];
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    dsr_r   <= dsr_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/stra_cfg_regs.sv =====
module stra_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stra_pkg::ADDR_W-1:0]   paddr,
  input  logic [stra_pkg::DATA_W-1:0]   pwdata,
  output logic [stra_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output stra_pkg::cfg_t                cfg
);
  import stra_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_cols    <= TILE_COLS_RESET;
      cfg_r.tile_rows    <= TILE_ROWS_RESET;
      cfg_r.store_width  <= STORE_WIDTH_RESET;
      cfg_r.store_height <= STORE_HEIGHT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_TILE_COLS:    cfg_r.tile_cols    <= pwdata[TILE_W-1:0];
        REG_TILE_ROWS:    cfg_r.tile_rows    <= pwdata[TILE_W-1:0];
        REG_STORE_WIDTH:  cfg_r.store_width  <= pwdata[DIM_W-1:0];
        REG_STORE_HEIGHT: cfg_r.store_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TILE_COLS:    prdata = DATA_W'(cfg_r.tile_cols);
      REG_TILE_ROWS:    prdata = DATA_W'(cfg_r.tile_rows);
      REG_STORE_WIDTH:  prdata = DATA_W'(cfg_r.store_width);
      REG_STORE_HEIGHT: prdata = DATA_W'(cfg_r.store_height);
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/shelf_tile_region_allocator.sv =====
// From input accept to result valid: two remainder passes (width, then height)
//   through one shared restoring divider, plus handoff and decide steps.
// Items go through one at a time; a new item is accepted only with the sequencer idle.
// A new item is accepted while the previous result still waits on out_tready.
// Reset (rst_n, synchronous, active low): registers to defaults, shelf state
//   to fill 0 / top 20000 / tallest 0, no result pending.
module shelf_tile_region_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  // input item
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [23:0] region_x, [47:24] region_y, [63:48] request_width, [79:64] request_height
  input  logic [stra_pkg::IN_W-1:0]         in_tdata,
  // result item
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [23:0] offset_x, [47:24] offset_y, [71:48] out_region_x, [95:72] out_region_y
  output logic [stra_pkg::OUT_W-1:0]        out_tdata,
  // [0] granted, [1] too_wide
  output logic [stra_pkg::OUT_USER_W-1:0]   out_tuser,
  // register port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [stra_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [stra_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [stra_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import stra_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIVW   = 3'd1;
  localparam logic [2:0] ST_DIVH   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;

  // size - 1, with a zero size rounded as one
  function automatic logic [REQ_W-1:0] size_m1(input logic [REQ_W-1:0] s);
    size_m1 = (s == '0) ? '0 : s - 1'b1;
  endfunction

  // zero tile treated as one
  function automatic logic [TILE_W-1:0] tile_eff(input logic [TILE_W-1:0] t);
    tile_eff = (t == '0) ? TILE_W'(1) : t;
  endfunction

  // (floor(sm1/t) + 5) * t == sm1 - rem + 5*t
  function automatic logic [PAD_W-1:0] pad_calc(input logic [REQ_W-1:0] sm1,
                                                input logic [TILE_W-1:0] r,
                                                input logic [TILE_W-1:0] t);
    pad_calc = ({1'b0, sm1} - {4'b0, r}) + ({2'b0, t, 2'b0} + {4'b0, t});
  endfunction

  cfg_t cfg;

  stra_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // sequencer and item registers
  logic [2:0]          state_r, state_nxt;
  logic [REGION_W-1:0] rx_r, ry_r;
  logic [REQ_W-1:0]    req_w_m1_r, req_h_m1_r;
  logic [PAD_W-1:0]    nw_r;

  // shelf state
  logic [ST_W-1:0]     fill_r, fill_nxt;
  logic [ST_W-1:0]     top_r, top_nxt;
  logic [ST_W-1:0]     tall_r, tall_nxt;

  // result register
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic in_acc;
  logic div_start, div_busy, div_done;
  logic [REQ_W-1:0]  div_dividend;
  logic [TILE_W-1:0] div_divisor;
  logic [TILE_W-1:0] div_rem;
  logic [PAD_W-1:0]  pad_val;
  logic out_free;
  logic load_out;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign load_out  = (state_r == ST_DECIDE) && out_free;

  // one divider, first for the width, then for the height
  assign div_start    = in_acc || ((state_r == ST_DIVW) && div_done);
  assign div_dividend = (state_r == ST_IDLE) ? size_m1(in_tdata[63:48]) : req_h_m1_r;
  assign div_divisor  = (state_r == ST_IDLE) ? tile_eff(cfg.tile_cols)
                                             : tile_eff(cfg.tile_rows);

  stra_rem_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .remainder (div_rem)
  );

  // padded size of the pass that just finished; registered into nw_r or nh_r
  assign pad_val = (state_r == ST_DIVW)
                   ? pad_calc(req_w_m1_r, div_rem, tile_eff(cfg.tile_cols))
                   : pad_calc(req_h_m1_r, div_rem, tile_eff(cfg.tile_rows));

  logic [PAD_W-1:0] nh;
  logic [CMP_W-1:0] sw27, sh27;
  logic [CMP_W-1:0] top_nh, top_tall_nh, fill_nw;
  logic             refuse_top, row_over, refuse_new, ok, new_shelf, wide;
  logic [ST_W-1:0]  base_top, base_fill, base_tall;
  logic [ST_W-1:0]  nh25;

  logic [PAD_W-1:0] nh_r;

  assign nh   = nh_r;
  assign nh25 = {8'b0, nh};
  assign sw27 = {3'b0, cfg.store_width};
  assign sh27 = {3'b0, cfg.store_height};

  // all sums at full precision, no wrap
  assign top_nh      = {2'b0, top_r} + {10'b0, nh};
  assign top_tall_nh = {2'b0, top_r} + {2'b0, tall_r} + {10'b0, nh};
  assign fill_nw     = {2'b0, fill_r} + {10'b0, nw_r};

  assign wide       = {10'b0, nw_r} > sw27;
  assign refuse_top = top_nh > sh27;
  assign row_over   = fill_nw > sw27;
  assign refuse_new = top_tall_nh > sh27;
  assign ok         = !refuse_top && !(row_over && refuse_new);
  assign new_shelf  = !refuse_top && row_over && !refuse_new;

  assign base_top  = new_shelf ? top_r + tall_r : top_r;
  assign base_fill = new_shelf ? '0 : fill_r;
  assign base_tall = new_shelf ? '0 : tall_r;

  always_comb begin
    fill_nxt = fill_r;
    top_nxt  = top_r;
    tall_nxt = tall_r;
    if (load_out && ok) begin
      top_nxt  = base_top;
      fill_nxt = base_fill + {8'b0, nw_r};
      tall_nxt = (base_tall < nh25) ? nh25 : base_tall;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_DIVW;
      ST_DIVW:   if (div_done) state_nxt = ST_DIVH;
      ST_DIVH:   if (div_done) state_nxt = ST_DECIDE;
      ST_DECIDE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      top_r       <= SHELF_TOP_RESET;
      tall_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      top_r   <= top_nxt;
      tall_r  <= tall_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rx_r       <= in_tdata[23:0];
      ry_r       <= in_tdata[47:24];
      req_w_m1_r <= size_m1(in_tdata[63:48]);
      req_h_m1_r <= size_m1(in_tdata[79:64]);
    end
    if ((state_r == ST_DIVW) && div_done) begin
      nw_r <= pad_val;
    end
    if ((state_r == ST_DIVH) && div_done) begin
      nh_r <= pad_val;
    end
    if (load_out) begin
      out_user_r <= {wide, ok};
      if (ok) begin
        out_data_r <= {ry_r, rx_r, base_top[DIM_W-1:0], base_fill[DIM_W-1:0]};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // ready for a new item only with the divider idle
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_busy)
    else $error("input ready while divider busy");

  // a refused result carries zero offsets and region
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("refused result with nonzero payload");

  // shelves only move down from the reset top
  a_top_floor: assert property (@(posedge clk) disable iff (!rst_n)
    top_r >= SHELF_TOP_RESET)
    else $error("shelf top below reset row");

  // divider completion only seen while the sequencer waits on it
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> ((state_r == ST_DIVW) || (state_r == ST_DIVH)))
    else $error("divider done outside a divide step");

endmodule

// ===== sim/placement_checker.sv =====
module placement_checker import stra_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // [23:0] region_x, [47:24] region_y, [63:48] request_width, [79:64] request_height
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [23:0] offset_x, [47:24] offset_y, [71:48] out_region_x, [95:72] out_region_y
  input  logic [OUT_W-1:0]      out_tdata,
  // [0] granted, [1] too_wide
  input  logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [DATA_W-1:0]     cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    outstanding,
  output int                    mismatches,
  output int                    granted_total,
  output int                    refused_total,
  output int                    shelves_opened
);

  localparam longint unsigned PAD_TILES = 5;

  typedef struct packed {
    logic                granted;
    logic                too_wide;
    logic [DIM_W-1:0]    offset_x;
    logic [DIM_W-1:0]    offset_y;
    logic [REGION_W-1:0] region_x;
    logic [REGION_W-1:0] region_y;
  } placement_t;

  cfg_t            regs;
  logic [ST_W-1:0] row_fill_x;
  logic [ST_W-1:0] shelf_top_y;
  logic [ST_W-1:0] shelf_tallest;
  placement_t      placements_due[$];

  // size rounded up to whole tiles plus the spare tiles; tile 0 counts as 1
  function automatic longint unsigned padded(input longint unsigned size,
                                             input logic [TILE_W-1:0] tile);
    longint unsigned t;
    longint unsigned q;
    t = (tile == 0) ? 1 : tile;
    q = (size == 0) ? 0 : (size - 1) / t;
    return (q + PAD_TILES) * t;
  endfunction

  function automatic placement_t place_request(input logic [IN_W-1:0] d);
    placement_t      r;
    longint unsigned nw;
    longint unsigned nh;
    logic            fits;
    nw = padded(d[63:48], regs.tile_cols);
    nh = padded(d[79:64], regs.tile_rows);
    r = '0;
    r.too_wide = nw > regs.store_width;
    fits = 1'b1;
    // the sums compared below are all taken in 64 bits, so none of them wraps
    if (shelf_top_y + nh > regs.store_height) begin
      fits = 1'b0;
    end else if (row_fill_x + nw > regs.store_width) begin
      if (shelf_top_y + shelf_tallest + nh > regs.store_height) begin
        fits = 1'b0;
      end else begin
        shelf_top_y   = shelf_top_y + shelf_tallest;
        row_fill_x    = '0;
        shelf_tallest = '0;
        shelves_opened++;
      end
    end
    if (fits) begin
      r.granted  = 1'b1;
      r.offset_x = row_fill_x[DIM_W-1:0];
      r.offset_y = shelf_top_y[DIM_W-1:0];
      r.region_x = d[23:0];
      r.region_y = d[47:24];
      row_fill_x = ST_W'(row_fill_x + nw);
      if (shelf_tallest < nh) shelf_tallest = ST_W'(nh);
      granted_total++;
    end else begin
      refused_total++;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    placement_t want;
    placement_t got;
    if (!rst_n) begin
      regs.tile_cols    = TILE_COLS_RESET;
      regs.tile_rows    = TILE_ROWS_RESET;
      regs.store_width  = STORE_WIDTH_RESET;
      regs.store_height = STORE_HEIGHT_RESET;
      row_fill_x        = '0;
      shelf_top_y       = SHELF_TOP_RESET;
      shelf_tallest     = '0;
      placements_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[ADDR_W-1:2])
          REG_TILE_COLS:    regs.tile_cols    = cfg_pwdata[TILE_W-1:0];
          REG_TILE_ROWS:    regs.tile_rows    = cfg_pwdata[TILE_W-1:0];
          REG_STORE_WIDTH:  regs.store_width  = cfg_pwdata[DIM_W-1:0];
          REG_STORE_HEIGHT: regs.store_height = cfg_pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) placements_due.push_back(place_request(in_tdata));
      if (out_tvalid && out_tready) begin
        if (placements_due.size() == 0) begin
          $error("placement result with no request waiting");
          mismatches++;
        end else begin
          want = placements_due.pop_front();
          got.granted  = out_tuser[0];
          got.too_wide = out_tuser[1];
          got.offset_x = out_tdata[23:0];
          got.offset_y = out_tdata[47:24];
          got.region_x = out_tdata[71:48];
          got.region_y = out_tdata[95:72];
          check_field("granted", 24'(want.granted), 24'(got.granted));
          check_field("too_wide", 24'(want.too_wide), 24'(got.too_wide));
          check_field("offset_x", want.offset_x, got.offset_x);
          check_field("offset_y", want.offset_y, got.offset_y);
          check_field("out_region_x", want.region_x, got.region_x);
          check_field("out_region_y", want.region_y, got.region_y);
        end
      end
      outstanding <= placements_due.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  import stra_pkg::*;

  localparam int SETTLE_CYCLES = 48;     // above the accept-to-result latency
  localparam int HOLD_CYCLES   = 600;    // long receiver hold-off
  localparam int LIMIT         = 1000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [23:0] region_x, [47:24] region_y, [63:48] request_width, [79:64] request_height
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [23:0] offset_x, [47:24] offset_y, [71:48] out_region_x, [95:72] out_region_y
  logic [OUT_W-1:0]      out_tdata;
  // [0] granted, [1] too_wide
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]     cfg_paddr = '0;
  logic [DATA_W-1:0]     cfg_pwdata = '0;
  logic [DATA_W-1:0]     cfg_prdata;
  logic                  cfg_pready;

  int outstanding;
  int mismatches;
  int granted_total;
  int refused_total;
  int shelves_opened;

  // stimulus bookkeeping
  bit calm = 1'b0;          // both sides run without gaps while set
  int holds_asked = 0;      // sender bumps this to ask for a receiver hold-off
  int holds_done = 0;
  int items_sent = 0;
  int settings_used = 0;
  int cycle_count = 0;

  shelf_tile_region_allocator DUT (.*);
  placement_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, with a long hold when the sender asks.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      out_tready <= calm || ($urandom_range(99) >= 30);
    end
  end

  function automatic logic [IN_W-1:0] pack_request(input logic [23:0] x, input logic [23:0] y,
                                                   input logic [15:0] w, input logic [15:0] h);
    return {h, w, y, x};
  endfunction

  // mostly full-range origins, sometimes the signed extremes
  function automatic logic [23:0] random_region();
    case ($urandom_range(9))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // mostly small regions so shelves fill gradually, some full range,
  // some tiny or zero, and the 16-bit extremes now and then
  function automatic logic [15:0] random_size();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(4000, 1));
    if (r < 85) return 16'($urandom_range(65535, 1));
    if (r < 95) return 16'($urandom_range(16, 0));
    return (r & 1) ? 16'hFFFF : 16'h0001;
  endfunction

  // Offers one item and returns at the edge that accepts it. Valid stays
  // high afterwards; the next call or a settle decides what comes next.
  task automatic send_request(input logic [IN_W-1:0] d);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 30) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stop offering, wait for every result, then let the pipeline go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup phase, access phase, then an idle gap with psel low before the next transfer
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_allocator(input int tc, input int tr, input int sw, input int sh);
    settle();
    write_reg(REG_TILE_COLS, tc);
    write_reg(REG_TILE_ROWS, tr);
    write_reg(REG_STORE_WIDTH, sw);
    write_reg(REG_STORE_HEIGHT, sh);
    settings_used++;
  endtask

  // Random items; hold_at / pause_at pick the item before which the receiver
  // holds off or the sender drains (-1 for none); calm_until runs gap-free.
  task automatic run_phase(input int n, input int hold_at, input int pause_at,
                           input int calm_until);
    for (int i = 0; i < n; i++) begin
      calm = i < calm_until;
      if (i == hold_at) holds_asked++;
      if (i == pause_at) settle();
      send_request(pack_request(random_region(), random_region(),
                                random_size(), random_size()));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: field extremes, zero sizes, exact and one-over tile sizes.
    send_request(pack_request(24'h000000, 24'h000000, 16'd1, 16'd1));
    send_request(pack_request(24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF));
    send_request(pack_request(24'h800000, 24'h7FFFFF, 16'd0, 16'd0));
    send_request(pack_request(24'hFFFFFF, 24'hFFFFFF, 16'd128, 16'd64));
    send_request(pack_request(24'h000001, 24'hFFFFFE, 16'd129, 16'd65));
    send_request(pack_request(24'h123456, 24'h654321, 16'hFFFE, 16'd1));

    // Narrow, short store: new shelves, over-wide flags, refusals for height.
    set_allocator(128, 64, 2000, 200000);
    send_request(pack_request(24'h000010, 24'h000020, 16'd100, 16'd100));
    send_request(pack_request(24'h000011, 24'h000021, 16'd100, 16'd100));
    send_request(pack_request(24'h000012, 24'h000022, 16'd100, 16'd100));
    send_request(pack_request(24'h000013, 24'h000023, 16'd1000, 16'd100));
    send_request(pack_request(24'h000014, 24'h000024, 16'hFFFF, 16'd30000));
    send_request(pack_request(24'h000015, 24'h000025, 16'd100, 16'hFFFF));
    send_request(pack_request(24'h000016, 24'h000026, 16'hFFFF, 16'hFFFF));
    send_request(pack_request(24'h000017, 24'h000027, 16'd5000, 16'hFFFF));
    send_request(pack_request(24'h000018, 24'h000028, 16'd10, 16'd10));

    // Zero tile sizes behave as one pixel.
    set_allocator(0, 0, 24'hFFFFFF, 24'hFFFFFF);
    send_request(pack_request(24'h0000AA, 24'h0000BB, 16'd0, 16'd0));
    send_request(pack_request(24'h0000AC, 24'h0000BD, 16'd1, 16'd1));
    send_request(pack_request(24'h0000AE, 24'h0000BF, 16'hFFFF, 16'hFFFF));

    // Random phases. Shelf top only grows, so the store height climbs from
    // phase to phase; each phase tends to run into its own height limit.
    set_allocator(128, 64, $urandom_range(40000, 5000), 3000000);
    run_phase(300, 100, -1, 0);
    // smallest store: everything refused and over-wide
    set_allocator(0, 0, 1, 1);
    run_phase(40, -1, -1, 0);
    // one-pixel-wide store: every item is wider than a row, so every granted item opens a shelf
    set_allocator(1, 1, 1, 3500000);
    run_phase(150, -1, -1, 0);
    set_allocator(8191, 4096, 24'hFFFFFF, 6000000);
    run_phase(250, -1, -1, 0);
    set_allocator($urandom_range(300, 1), $urandom_range(300, 1),
                  $urandom_range(500000, 50000), 9000000);
    run_phase(300, -1, -1, 150);
    set_allocator($urandom_range(4096, 1), $urandom_range(4096, 1),
                  $urandom_range(200000, 1), 12000000);
    run_phase(300, -1, 150, 0);
    set_allocator(4096, 8191, $urandom_range(24'hFFFFFF, 100000), 24'hFFFFFF);
    run_phase(300, -1, -1, 0);
    set_allocator(128, 64, 24'hFFFFFF, 24'hFFFFFF);
    run_phase(300, -1, -1, 0);

    settle();
    $display("%0d requests under %0d register settings", items_sent, settings_used);
    $display("%0d granted, %0d refused, %0d shelves opened",
             granted_total, refused_total, shelves_opened);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
